// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int UNIT_COUNT = 128;
  localparam int UNIT_BYTES = 16;
  localparam int IDX_W      = $clog2(UNIT_COUNT);
  localparam int REQ_W      = 16;
  localparam int WANT_W     = REQ_W + 1 - $clog2(UNIT_BYTES);

  localparam logic [IDX_W-1:0] SIZE_INIT = IDX_W'(UNIT_COUNT - 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(UNIT_COUNT - 1);

  // write port of one store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } wr_t;

endpackage

// ===== hw/rtl/ffa_store.sv =====
// ----------------------------------------------------------------------------
// ffa_store
// Header store: one write and one registered read a cycle. Entries never
// written read as the reset value (entry 0 gives init0_i, others zero).
// ----------------------------------------------------------------------------
module ffa_store (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ffa_pkg::wr_t            wr_i,
  input  logic [ffa_pkg::IDX_W-1:0] raddr_i,
  input  logic [ffa_pkg::IDX_W-1:0] init0_i,
  output logic [ffa_pkg::IDX_W-1:0] rdata_o
);

  logic [ffa_pkg::IDX_W-1:0] mem [ffa_pkg::UNIT_COUNT];
  logic [ffa_pkg::UNIT_COUNT-1:0] valid_q;
  logic [ffa_pkg::IDX_W-1:0] rd_q;
  logic [ffa_pkg::IDX_W-1:0] raddr_q;
  logic                      rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      raddr_q  <= '0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
      raddr_q  <= raddr_i;
    end
  end

  assign rdata_o = rvalid_q ? rd_q : ((raddr_q == '0) ? init0_i : '0);

endmodule

// ===== hw/rtl/ffa_alu.sv =====
// ----------------------------------------------------------------------------
// ffa_alu
// Shared header adder: a + 1 + b, saturated copy and compare against cmp.
// ----------------------------------------------------------------------------
module ffa_alu (
  input  logic [ffa_pkg::IDX_W-1:0] a_i,
  input  logic [ffa_pkg::IDX_W-1:0] b_i,
  input  logic [ffa_pkg::IDX_W-1:0] cmp_i,
  output logic [ffa_pkg::IDX_W:0]   sum_o,
  output logic [ffa_pkg::IDX_W-1:0] sat_o,
  output logic                      eq_o
);

  assign sum_o = {1'b0, a_i} + {1'b0, b_i} + (ffa_pkg::IDX_W+1)'(1);
  assign sat_o = (sum_o > {1'b0, ffa_pkg::IDX_LAST}) ? ffa_pkg::IDX_LAST
                                                     : sum_o[ffa_pkg::IDX_W-1:0];
  assign eq_o  = (sum_o == {1'b0, cmp_i});

endmodule

// ===== hw/rtl/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// Circular first-fit free-list allocator over a heap of 128 units.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser is the mode (0 allocate, 1 free); tdata holds
// request_bytes in [15:0] and release_index in [22:16]. Output channel
// m_axis: tdata[6:0] is granted_index, tuser is status (1 failed/ignored).
// Every item gives exactly one result item.
// One item is worked at a time; s_axis_tready is high only while the
// sequencer is idle. An allocate walks the free list, checking up to 128
// free blocks, and takes an extra step when a block is split. A free walks
// the list to find its place and then merges with each adjacent free
// neighbour. Items rejected at once go straight to the result. The walk
// through the link store does one registered read a node.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds the sequencer only when a second result
// is ready. After reset the heap is one free block of 127 units at header 0;
// the stores read their reset value through per-entry valid bits, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // request_bytes[15:0], release_index[22:16]
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // granted_index[6:0]
  output logic        m_axis_tuser    // status
);

  localparam int W = ffa_pkg::IDX_W;
  localparam int REQ_SUM_W = ffa_pkg::REQ_W + 1;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_A_RL   = 15'b000000000000010,
    ST_A_RU   = 15'b000000000000100,
    ST_A_CHK  = 15'b000000000001000,
    ST_A_SPL  = 15'b000000000010000,
    ST_A_HEAD = 15'b000000000100000,
    ST_F_RL   = 15'b000000001000000,
    ST_F_CHK  = 15'b000000010000000,
    ST_F_W2   = 15'b000000100000000,
    ST_F_RF   = 15'b000001000000000,
    ST_F_MR   = 15'b000010000000000,
    ST_F_RH   = 15'b000100000000000,
    ST_F_LM   = 15'b001000000000000,
    ST_F_LW   = 15'b010000000000000,
    ST_DONE   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [W-1:0] head_q, head_d;
  logic         empty_q, empty_d;
  logic [W-1:0] b_q, b_d, use_q, use_d, lu_q, lu_d, tail_q, tail_d;
  logic [W-1:0] f_q, f_d, nx_q, nx_d, sf_q, sf_d, lf_q, lf_d, sh_q, sh_d;
  logic         split_q, split_d;
  logic [W-1:0] cnt_q, cnt_d;
  logic [ffa_pkg::WANT_W-1:0] want_q, want_d;
  logic [W-1:0] res_idx_q, res_idx_d;
  logic         res_st_q, res_st_d;
  logic         m_valid_q;
  logic [W-1:0] m_idx_q;
  logic         m_st_q;

  ffa_pkg::wr_t lw, sw;
  logic [W-1:0] l_raddr, s_raddr, l_rd, s_rd;
  logic [W-1:0] alu_a, alu_b, alu_c, alu_sat, nlu;
  logic [W:0]   alu_sum;
  logic         alu_eq, accept, out_free, fcond;
  logic [REQ_SUM_W-1:0] req_sum;

  ffa_store u_link (
    .clk_i, .rst_ni, .wr_i(lw), .raddr_i(l_raddr), .init0_i('0), .rdata_o(l_rd)
  );
  ffa_store u_size (
    .clk_i, .rst_ni, .wr_i(sw), .raddr_i(s_raddr), .init0_i(ffa_pkg::SIZE_INIT),
    .rdata_o(s_rd)
  );
  ffa_alu u_alu (
    .a_i(alu_a), .b_i(alu_b), .cmp_i(alu_c), .sum_o(alu_sum), .sat_o(alu_sat),
    .eq_o(alu_eq)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign req_sum       = REQ_SUM_W'(s_axis_tdata[15:0]) + REQ_SUM_W'(ffa_pkg::UNIT_BYTES - 1);
  assign fcond = ((l_rd > b_q) && (f_q > b_q) && (f_q < l_rd)) ||
                 ((l_rd <= b_q) && (f_q > b_q)) || ((l_rd <= b_q) && (f_q < l_rd));
  // link of the split-off tail header; the tail itself when a self-looped block is split
  assign nlu = (split_q && (use_q == b_q)) ? tail_q : lu_q;

  always_comb begin
    state_d = state_q;  head_d = head_q;  empty_d = empty_q;
    b_d = b_q;  use_d = use_q;  lu_d = lu_q;  tail_d = tail_q;
    f_d = f_q;  nx_d = nx_q;  sf_d = sf_q;  lf_d = lf_q;  sh_d = sh_q;
    split_d = split_q;  cnt_d = cnt_q;  want_d = want_q;
    res_idx_d = res_idx_q;  res_st_d = res_st_q;
    lw = '0;  sw = '0;
    l_raddr = b_q;  s_raddr = b_q;
    alu_a = use_q;  alu_b = want_q[W-1:0];  alu_c = nx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_idx_d = '0;
          res_st_d  = 1'b1;
          cnt_d     = '0;
          b_d       = head_q;
          want_d    = ffa_pkg::WANT_W'(req_sum / ffa_pkg::UNIT_BYTES);
          f_d       = s_axis_tdata[22:16] - W'(1);
          if (!s_axis_tuser) begin
            state_d = (s_axis_tdata[15:0] == '0 || empty_q) ? ST_DONE : ST_A_RL;
          end else if (s_axis_tdata[22:16] == '0) begin
            state_d = ST_DONE;
          end else if (empty_q) begin
            lw = '{we: 1'b1, addr: s_axis_tdata[22:16] - W'(1),
                   data: s_axis_tdata[22:16] - W'(1)};
            empty_d  = 1'b0;
            head_d   = s_axis_tdata[22:16] - W'(1);
            res_st_d = 1'b0;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_F_RL;
          end
        end
      end
      ST_A_RL: state_d = ST_A_RU;
      ST_A_RU: begin
        use_d   = l_rd;
        l_raddr = l_rd;
        s_raddr = l_rd;
        state_d = ST_A_CHK;
      end
      ST_A_CHK: begin
        lu_d = l_rd;
        if ({{(ffa_pkg::WANT_W-W){1'b0}}, s_rd} >= want_q) begin
          if ({{(ffa_pkg::WANT_W-W){1'b0}}, s_rd} == want_q) begin
            lw      = '{we: 1'b1, addr: b_q, data: l_rd};
            split_d = 1'b0;
          end else begin
            lw      = '{we: 1'b1, addr: b_q, data: alu_sum[W-1:0]};
            sw      = '{we: 1'b1, addr: alu_sum[W-1:0],
                        data: s_rd - want_q[W-1:0] - W'(1)};
            tail_d  = alu_sum[W-1:0];
            split_d = 1'b1;
          end
          state_d = split_d ? ST_A_SPL : ST_A_HEAD;
        end else if (use_q == head_q || cnt_q == ffa_pkg::IDX_LAST) begin
          state_d = ST_DONE;
        end else begin
          // next node's link already read: check it straight away
          b_d     = use_q;
          use_d   = l_rd;
          l_raddr = l_rd;
          s_raddr = l_rd;
          cnt_d   = cnt_q + W'(1);
        end
      end
      ST_A_SPL: begin
        lw      = '{we: 1'b1, addr: tail_q, data: nlu};
        sw      = '{we: 1'b1, addr: use_q, data: want_q[W-1:0]};
        state_d = ST_A_HEAD;
      end
      ST_A_HEAD: begin
        if (use_q == head_q) begin
          if (nlu == use_q) begin
            empty_d = 1'b1;
            head_d  = '0;
          end else begin
            head_d = nlu;
          end
        end
        res_idx_d = use_q + W'(1);
        res_st_d  = 1'b0;
        state_d   = ST_DONE;
      end
      ST_F_RL: state_d = ST_F_CHK;
      ST_F_CHK: begin
        if (fcond) begin
          lw      = '{we: 1'b1, addr: f_q, data: l_rd};
          nx_d    = l_rd;
          state_d = ST_F_W2;
        end else if (cnt_q == ffa_pkg::IDX_LAST) begin
          state_d = ST_DONE;
        end else begin
          b_d     = l_rd;
          l_raddr = l_rd;
          cnt_d   = cnt_q + W'(1);
        end
      end
      ST_F_W2: begin
        lw      = '{we: 1'b1, addr: b_q, data: f_q};
        s_raddr = f_q;
        state_d = ST_F_RF;
      end
      ST_F_RF: begin
        alu_a = f_q;
        alu_b = s_rd;
        alu_c = nx_q;
        sf_d  = s_rd;
        lf_d  = nx_q;
        if (alu_eq) begin
          l_raddr = nx_q;
          s_raddr = nx_q;
          state_d = ST_F_MR;
        end else begin
          state_d = ST_F_RH;
        end
      end
      ST_F_MR: begin
        alu_a   = sf_q;
        alu_b   = s_rd;
        sw      = '{we: 1'b1, addr: f_q, data: alu_sat};
        lw      = '{we: 1'b1, addr: f_q, data: l_rd};
        sf_d    = alu_sat;
        lf_d    = l_rd;
        head_d  = f_q;
        state_d = ST_F_RH;
      end
      ST_F_RH: state_d = ST_F_LM;
      ST_F_LM: begin
        alu_a    = b_q;
        alu_b    = s_rd;
        alu_c    = f_q;
        sh_d     = s_rd;
        res_st_d = 1'b0;
        state_d  = alu_eq ? ST_F_LW : ST_DONE;
      end
      ST_F_LW: begin
        alu_a   = sh_q;
        alu_b   = sf_q;
        sw      = '{we: 1'b1, addr: b_q, data: alu_sat};
        lw      = '{we: 1'b1, addr: b_q, data: lf_q};
        head_d  = b_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      empty_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      empty_q <= empty_d;
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;  use_q <= use_d;  lu_q <= lu_d;  tail_q <= tail_d;
    f_q <= f_d;  nx_q <= nx_d;  sf_q <= sf_d;  lf_q <= lf_d;  sh_q <= sh_d;
    split_q <= split_d;  cnt_q <= cnt_d;  want_q <= want_d;
    res_idx_q <= res_idx_d;  res_st_q <= res_st_d;
    if (state_q == ST_DONE && out_free) begin
      m_idx_q <= res_idx_q;
      m_st_q  <= res_st_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_idx_q};
  assign m_axis_tuser  = m_st_q;

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0)) else $error("empty list with non-null head");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE)) else $error("item accepted without work");
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !accept) |-> (!lw.we && !sw.we))
    else $error("store written while idle");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("result not loaded");

endmodule
